// ===== rtl/gpld_pkg.sv =====
// Shared types and constants of the grid path loop detector.
// No dependencies; imported by gpld_cfg and grid_path_loop_detector.
package gpld_pkg;

    // Diagonal direction marks kept per 2x2 block.
    localparam logic [1:0] DIAG_RISE = 2'b01;
    localparam logic [1:0] DIAG_FALL = 2'b10;

    // Register map, indexed by paddr[2].
    localparam logic REG_STOP_AT_FIRST = 1'b0;
    localparam logic REG_SPUR_WINDOW   = 1'b1;

    localparam logic [15:0] SPUR_WINDOW_RESET = 16'd2;
    localparam logic [15:0] SAT_MAX           = 16'hFFFF;

    // Width of the table epoch tags.
    localparam int EPOCH_W = 8;

    typedef struct packed {
        logic        stop_at_first;
        logic [15:0] spur_window;
    } cfg_t;

endpackage

// ===== rtl/gpld_cfg.sv =====
// Configuration registers of the grid path loop detector, behind an APB-style port.
// Depends on gpld_pkg.
module gpld_cfg
    import gpld_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stop_at_first <= 1'b0;
            cfg_reg.spur_window   <= SPUR_WINDOW_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_STOP_AT_FIRST: cfg_reg.stop_at_first <= pwdata[0];
                REG_SPUR_WINDOW:   cfg_reg.spur_window   <= pwdata[15:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_STOP_AT_FIRST: prdata = {31'd0, cfg_reg.stop_at_first};
            REG_SPUR_WINDOW:   prdata = {16'd0, cfg_reg.spur_window};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/grid_path_loop_detector.sv =====
// Top level of the grid path loop detector: item control, table memories, result register.
// Depends on gpld_pkg and gpld_cfg.
//
// Usage: path cells enter on the input channel (in_valid, in_stall, cell_x, cell_y,
// path_start), one cell per item. Every item produces exactly one result item on the
// output channel (out_valid, out_stall, hit ... overflow). A result says whether the
// cell closes a loop, either by revisiting a cell beyond the spur window or by
// crossing the other diagonal of a 2x2 block, and carries the running path totals.
// Each item is accepted in ST_IDLE, has its synchronous table reads in ST_READ, and is
// checked in ST_PROC, which writes the tables back and loads the result register. The
// block takes no new item until the last has left ST_PROC; the per-cell and per-block
// tables sit in single-port-write memories with registered reads, and this read/modify/write loop is why.
// out_valid is registered and rises as the result register is loaded. A result held
// by out_stall does not block acceptance of the next item, but that item waits in
// its check cycle until the result register is free.
// Tables are cleared by bumping an epoch tag. After reset, and whenever the tag
// wraps (every 255 clears), a pass writes every entry, one per cycle, followed by a
// write-back in ST_WB; in_stall is high throughout. A path start item that causes the
// wrap is processed after the pass.
// Configuration writes are taken at any time on the APB-style port.
module grid_path_loop_detector
    import gpld_pkg::*;
#(
    parameter int GRID_WIDTH     = 64,
    parameter int GRID_HEIGHT    = 64,
    parameter int MAX_PATH_CELLS = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [5:0]  cell_x,
    input  logic [5:0]  cell_y,
    input  logic        path_start,
    // result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic        hit_kind,
    output logic [5:0]  hit_x,
    output logic [5:0]  hit_y,
    output logic [15:0] first_index,
    output logic [15:0] second_index,
    output logic [15:0] hit_count,
    output logic [15:0] spur_ignored,
    output logic [15:0] max_spur_distance,
    output logic        stopped,
    output logic        overflow
);

    localparam int DEPTH   = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W   = $clog2(MAX_PATH_CELLS);
    localparam int CNT_W   = $clog2(MAX_PATH_CELLS + 1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [IDX_W-1:0]   idx;
    } cell_entry_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [1:0]         mask;
        logic [IDX_W-1:0]   rise;
        logic [IDX_W-1:0]   fall;
    } diag_entry_t;

    typedef struct packed {
        logic        hit;
        logic        kind;
        logic [5:0]  x;
        logic [5:0]  y;
        logic [15:0] first;
        logic [15:0] second;
        logic [15:0] hits;
        logic [15:0] spurs;
        logic [15:0] spmax;
        logic        stopped;
        logic        ovf;
    } result_t;

    typedef enum logic [2:0] {ST_CLEAR, ST_WB, ST_IDLE, ST_READ, ST_PROC} state_t;

    cfg_t cfg;

    gpld_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Memories.
    cell_entry_t cell_mem [DEPTH];
    diag_entry_t diag_mem [DEPTH];
    cell_entry_t cell_rd_reg;
    diag_entry_t diag_rd_reg;

    logic        c_we, d_we;
    logic [AW-1:0] c_waddr, d_waddr, c_raddr, d_raddr;
    cell_entry_t c_wdata;
    diag_entry_t d_wdata;

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            cell_mem[c_waddr] <= c_wdata;
        end
        if (d_we)
        begin
            diag_mem[d_waddr] <= d_wdata;
        end
        cell_rd_reg <= cell_mem[c_raddr];
        diag_rd_reg <= diag_mem[d_raddr];
    end

    // Control and path state.
    state_t             state_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic               pend_reg;
    logic               resume_reg;
    logic [AW-1:0]      pend_addr_reg;
    logic [IDX_W-1:0]   pend_idx_reg;
    logic [5:0]         it_x_reg, it_y_reg;
    logic [5:0]         prev_x_reg, prev_y_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [15:0]        hits_reg, spur_reg, spmax_reg;
    logic               halted_reg, ovf_reg;
    logic               out_valid_reg;
    result_t            res_reg;

    logic               in_ok;
    logic [AW-1:0]      cell_addr;
    logic               xup, yup;
    logic [5:0]         bx, by;
    logic [1:0]         dbit;
    logic               diag_step;
    logic               skip, too_long, active;
    logic [IDX_W-1:0]   j;
    logic               c_valid;
    logic [1:0]         d_mask;
    logic               dhit, rhit, p_hit, spur_ok;
    logic [IDX_W-1:0]   gap, first;
    logic               proc_go;
    logic               spur_take, wrap_hit, bump_hit;
    logic [15:0]        hits_next, spur_next, spmax_next;
    logic               halted_next, ovf_next;
    logic               out_valid_next;
    result_t            res_next;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_ok    = in_valid && !in_stall;

    always_comb
    begin
        cell_addr = AW'(32'(it_y_reg) * GRID_WIDTH + 32'(it_x_reg));
        xup       = it_x_reg > prev_x_reg;
        yup       = it_y_reg > prev_y_reg;
        bx        = xup ? prev_x_reg : it_x_reg;
        by        = yup ? prev_y_reg : it_y_reg;
        dbit      = (xup == yup) ? DIAG_RISE : DIAG_FALL;
        c_raddr   = cell_addr;
        d_raddr   = AW'(32'(by) * GRID_WIDTH + 32'(bx));

        skip      = halted_reg || (32'(it_x_reg) >= GRID_WIDTH)
                    || (32'(it_y_reg) >= GRID_HEIGHT);
        too_long  = 32'(cnt_reg) >= MAX_PATH_CELLS;
        active    = !skip && !too_long;
        j         = IDX_W'(cnt_reg);
        diag_step = (cnt_reg != '0) && (it_x_reg != prev_x_reg) && (it_y_reg != prev_y_reg);

        c_valid   = cell_rd_reg.tag == epoch_reg;
        d_mask    = (diag_rd_reg.tag == epoch_reg) ? diag_rd_reg.mask : 2'b00;
        dhit      = diag_step && ((d_mask & ~dbit) != 2'b00);
        gap       = j - cell_rd_reg.idx;
        spur_ok   = 32'(gap) <= 32'(cfg.spur_window);
        rhit      = !dhit && c_valid && !spur_ok;
        p_hit     = active && (dhit || rhit);
        first     = dhit ? ((dbit == DIAG_RISE) ? diag_rd_reg.fall : diag_rd_reg.rise)
                         : cell_rd_reg.idx;
        proc_go   = (state_reg == ST_PROC) && !(out_valid_reg && out_stall);

        // Path totals and result after the item in the check cycle.
        spur_take   = active && !p_hit && c_valid && spur_ok;
        spur_next   = (spur_take && (spur_reg != SAT_MAX)) ? spur_reg + 16'd1 : spur_reg;
        spmax_next  = (spur_take && (32'(gap) > 32'(spmax_reg))) ? 16'(gap) : spmax_reg;
        hits_next   = (p_hit && (hits_reg != SAT_MAX)) ? hits_reg + 16'd1 : hits_reg;
        halted_next = halted_reg || (p_hit && cfg.stop_at_first);
        ovf_next    = ovf_reg || (!skip && too_long);
        wrap_hit    = p_hit && !cfg.stop_at_first && (epoch_reg == EPOCH_LAST);
        bump_hit    = p_hit && !cfg.stop_at_first && (epoch_reg != EPOCH_LAST);

        res_next = '{hit:     p_hit,
                     kind:    p_hit && dhit,
                     x:       p_hit ? it_x_reg : 6'd0,
                     y:       p_hit ? it_y_reg : 6'd0,
                     first:   p_hit ? 16'(first) : 16'd0,
                     second:  p_hit ? 16'(j) : 16'd0,
                     hits:    hits_next,
                     spurs:   spur_next,
                     spmax:   spmax_next,
                     stopped: halted_next,
                     ovf:     ovf_next};

        if (proc_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        c_we    = 1'b0;
        c_waddr = cell_addr;
        c_wdata = '{tag: epoch_reg, idx: j};
        d_we    = 1'b0;
        d_waddr = d_raddr;
        d_wdata = '{tag: epoch_reg, mask: d_mask | dbit,
                    rise: (dbit == DIAG_RISE) ? j : diag_rd_reg.rise,
                    fall: (dbit == DIAG_FALL) ? j : diag_rd_reg.fall};

        if (state_reg == ST_CLEAR)
        begin
            c_we    = 1'b1;
            c_waddr = clr_addr_reg;
            c_wdata = '{tag: '0, idx: '0};
            d_we    = 1'b1;
            d_waddr = clr_addr_reg;
            d_wdata = '{tag: '0, mask: 2'b00, rise: '0, fall: '0};
        end
        else if (state_reg == ST_WB)
        begin
            c_we    = pend_reg;
            c_waddr = pend_addr_reg;
            c_wdata = '{tag: epoch_reg, idx: pend_idx_reg};
        end
        else if (proc_go && active)
        begin
            d_we = diag_step && !dhit && !rhit;
            if (!p_hit)
            begin
                c_we = !c_valid || spur_ok;
            end
            else if (!cfg.stop_at_first && (epoch_reg != EPOCH_LAST))
            begin
                // The tables are cleared by the new epoch; record this cell in it.
                c_we    = 1'b1;
                c_wdata = '{tag: epoch_reg + EPOCH_FIRST, idx: j};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            epoch_reg     <= EPOCH_FIRST;
            pend_reg      <= 1'b0;
            resume_reg    <= 1'b0;
            pend_addr_reg <= '0;
            pend_idx_reg  <= '0;
            it_x_reg      <= '0;
            it_y_reg      <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            cnt_reg       <= '0;
            hits_reg      <= '0;
            spur_reg      <= '0;
            spmax_reg     <= '0;
            halted_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (32'(clr_addr_reg) == DEPTH - 1)
                    begin
                        clr_addr_reg <= '0;
                        state_reg    <= ST_WB;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + AW'(1);
                    end
                end
                ST_WB:
                begin
                    // A path start item that forced the sweep, if any, is still waiting.
                    pend_reg   <= 1'b0;
                    resume_reg <= 1'b0;
                    state_reg  <= resume_reg ? ST_READ : ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (in_ok)
                    begin
                        it_x_reg <= cell_x;
                        it_y_reg <= cell_y;
                        if (path_start)
                        begin
                            prev_x_reg <= '0;
                            prev_y_reg <= '0;
                            cnt_reg    <= '0;
                            hits_reg   <= '0;
                            spur_reg   <= '0;
                            spmax_reg  <= '0;
                            halted_reg <= 1'b0;
                            ovf_reg    <= 1'b0;
                            if (epoch_reg == EPOCH_LAST)
                            begin
                                epoch_reg  <= EPOCH_FIRST;
                                resume_reg <= 1'b1;
                                state_reg  <= ST_CLEAR;
                            end
                            else
                            begin
                                epoch_reg <= epoch_reg + EPOCH_FIRST;
                                state_reg <= ST_READ;
                            end
                        end
                        else
                        begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_PROC;
                end
                ST_PROC:
                begin
                    if (proc_go)
                    begin
                        res_reg    <= res_next;
                        hits_reg   <= hits_next;
                        spur_reg   <= spur_next;
                        spmax_reg  <= spmax_next;
                        halted_reg <= halted_next;
                        ovf_reg    <= ovf_next;
                        if (active)
                        begin
                            prev_x_reg <= it_x_reg;
                            prev_y_reg <= it_y_reg;
                            cnt_reg    <= cnt_reg + CNT_W'(1);
                        end
                        if (wrap_hit)
                        begin
                            // Tag wrap: sweep the tables, then record this cell.
                            epoch_reg     <= EPOCH_FIRST;
                            pend_reg      <= 1'b1;
                            pend_addr_reg <= cell_addr;
                            pend_idx_reg  <= j;
                            state_reg     <= ST_CLEAR;
                        end
                        else
                        begin
                            if (bump_hit)
                            begin
                                epoch_reg <= epoch_reg + EPOCH_FIRST;
                            end
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid         = out_valid_reg;
    assign hit               = res_reg.hit;
    assign hit_kind          = res_reg.kind;
    assign hit_x             = res_reg.x;
    assign hit_y             = res_reg.y;
    assign first_index       = res_reg.first;
    assign second_index      = res_reg.second;
    assign hit_count         = res_reg.hits;
    assign spur_ignored      = res_reg.spurs;
    assign max_spur_distance = res_reg.spmax;
    assign stopped           = res_reg.stopped;
    assign overflow          = res_reg.ovf;

endmodule
